>>> src/cdms_pkg.sv
// ----------------------------------------------------------------------------
// cdms_pkg: shared constants and helpers for the clock display serializer
// Glyph tables, digit split, frame layout sizes and the decode-to-serializer
// control struct.
// ----------------------------------------------------------------------------
package cdms_pkg;

    localparam int DIGITS_PER_MODULE = 4;
    localparam int POS_W             = (DIGITS_PER_MODULE > 2) ? $clog2(DIGITS_PER_MODULE) : 1;
    localparam int FRAME_W           = 32;
    localparam int BIT_CNT_W         = $clog2(FRAME_W);
    localparam int VALUE_W           = 7;
    localparam int SEG_W             = 8;
    localparam int TIME_DIGITS       = 6;

    localparam logic [1:0] MODE_DASH   = 2'd0;
    localparam logic [1:0] MODE_CD     = 2'd1;
    localparam logic [1:0] MODE_SA     = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic CMD_SET_TIME = 1'b0;
    localparam logic CMD_SCAN     = 1'b1;

    localparam logic [SEG_W-1:0] GLYPH_OFF    = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_DOT_MASK = 8'h7F;

    localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    typedef struct packed {
        logic               load;
        logic [FRAME_W-1:0] frame;
    } frame_load_t;

    // Segment pattern of one decimal digit, blank above nine
    function automatic logic [SEG_W-1:0] glyph_of(input logic [3:0] v);
        logic [SEG_W-1:0] g;
        g = GLYPH_OFF;
        if (v < 4'd10)
        begin
            g = DIGIT_GLYPH[v];
        end
        return g;
    endfunction

    // Tens digit by reciprocal multiply: exact for every 7-bit value
    function automatic logic [3:0] tens_of(input logic [VALUE_W-1:0] v);
        logic [14:0] prod;
        prod = 15'(v) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] t10;
        t10 = VALUE_W'(tens_of(v)) * VALUE_W'(10);
        return 4'(v - t10);
    endfunction

    // Mode text glyph for module-1 digit 0 or 1
    function automatic logic [SEG_W-1:0] text_glyph(input logic [1:0] mode, input logic idx);
        logic [SEG_W-1:0] g;
        case (mode)
            MODE_CD: g = idx ? 8'hA1 : 8'hC6;
            MODE_SA: g = idx ? 8'h88 : 8'h92;
            default: g = 8'hBF;
        endcase
        return g;
    endfunction

endpackage

>>> src/clock_display_mux_serializer_core.sv
// ----------------------------------------------------------------------------
// clock_display_mux_serializer_core: two-module seven-segment scan serializer
//
// Channel   Dir  Signals                           Contents
// s_axis    in   tvalid/tready/tdata[23:0]/tuser   set-time or scan tick
// m_axis    out  tvalid/tready/tdata[7:0]/tlast    one serial bit, latch mark
// cfg       in   cfg_we/cfg_wdata[1:0]             mode text select
//
// A set-time transaction updates the stored digits; a scan tick produces 32
// output transactions, one per cycle unless stalled, set by the single shift register.
// The next scan frame loads in the cycle its predecessor's last bit is taken.
// Reset clears the segment registers to zero, the scan position to 0 and mode to dashes.
// Output stalls hold the shift register; a waiting scan tick holds the input.
// ----------------------------------------------------------------------------
module clock_display_mux_serializer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // hours[6:0], minutes[13:7], seconds[20:14], zero
    input  logic        s_axis_tuser,   // cmd: 0 set-time, 1 scan tick
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // serial_bit[0], zero
    output logic        m_axis_tlast,   // latch_after
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);
    import cdms_pkg::*;

    frame_load_t frame_load;
    logic        load_ready;

    cdms_decode u_decode
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .load_ready    (load_ready),
        .frame_load    (frame_load)
    );

    cdms_serializer u_serializer
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_load    (frame_load),
        .load_ready    (load_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A frame never overwrites bits still waiting to go out
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_load.load |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
        else $error("frame loaded over an unfinished frame");

    // A loaded frame shows up on the output in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_load.load |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("loaded frame not presented");

    // Mid-frame bits keep the output busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("frame cut short");

endmodule

>>> src/cdms_decode.sv
// ----------------------------------------------------------------------------
// cdms_decode: input register, display state and frame build
// Holds the incoming transaction, keeps the digit segments, mode text and
// scan position, and builds the 32-bit frame for each scan tick.
// ----------------------------------------------------------------------------
module cdms_decode
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_wdata,
    input  logic                          load_ready,
    output cdms_pkg::frame_load_t         frame_load
);
    import cdms_pkg::*;

    logic               in_valid_reg;
    logic               in_cmd_reg;
    logic [VALUE_W-1:0] in_hours_reg;
    logic [VALUE_W-1:0] in_minutes_reg;
    logic [VALUE_W-1:0] in_seconds_reg;

    logic [SEG_W-1:0]   seg_reg  [TIME_DIGITS];
    logic [SEG_W-1:0]   seg_next [TIME_DIGITS];
    logic [1:0]         mode_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;

    logic               consume;
    logic [3:0]         digit;
    logic [SEG_W-1:0]   mod1_byte;
    logic [SEG_W-1:0]   mod2_byte;
    logic [SEG_W-1:0]   sel_byte;

    assign consume       = in_valid_reg && ((in_cmd_reg == CMD_SET_TIME) || load_ready);
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg     <= s_axis_tuser;
            in_hours_reg   <= s_axis_tdata[6:0];
            in_minutes_reg <= s_axis_tdata[13:7];
            in_seconds_reg <= s_axis_tdata[20:14];
        end
    end

    // Set-time: split each value and store glyphs, dots on hour and minute ones
    always_comb
    begin
        for (int i = 0; i < TIME_DIGITS; i++)
        begin
            seg_next[i] = seg_reg[i];
        end
        if (consume && (in_cmd_reg == CMD_SET_TIME))
        begin
            seg_next[0] = glyph_of(tens_of(in_hours_reg));
            seg_next[1] = glyph_of(ones_of(in_hours_reg)) & SEG_DOT_MASK;
            seg_next[2] = glyph_of(tens_of(in_minutes_reg));
            seg_next[3] = glyph_of(ones_of(in_minutes_reg)) & SEG_DOT_MASK;
            seg_next[4] = glyph_of(tens_of(in_seconds_reg));
            seg_next[5] = glyph_of(ones_of(in_seconds_reg));
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (consume && (in_cmd_reg == CMD_SCAN))
        begin
            if (pos_reg == POS_W'(DIGITS_PER_MODULE - 1))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TIME_DIGITS; i++)
            begin
                seg_reg[i] <= '0;
            end
            pos_reg  <= '0;
            mode_reg <= MODE_DASH;
        end
        else
        begin
            seg_reg <= seg_next;
            pos_reg <= pos_next;
            // Drop writes of the unused mode code
            if (cfg_we && (cfg_wdata != MODE_UNUSED))
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    assign digit    = 4'(DIGITS_PER_MODULE - 1) - 4'(pos_reg);
    assign sel_byte = SEG_W'(1) << pos_reg;

    always_comb
    begin
        case (digit)
            4'd0:    mod1_byte = text_glyph(mode_reg, 1'b0);
            4'd1:    mod1_byte = text_glyph(mode_reg, 1'b1);
            4'd2:    mod1_byte = seg_reg[0];
            4'd3:    mod1_byte = seg_reg[1];
            default: mod1_byte = GLYPH_OFF;
        endcase
        case (digit)
            4'd0:    mod2_byte = seg_reg[2];
            4'd1:    mod2_byte = seg_reg[3];
            4'd2:    mod2_byte = seg_reg[4];
            4'd3:    mod2_byte = seg_reg[5];
            default: mod2_byte = GLYPH_OFF;
        endcase
    end

    assign frame_load.load  = in_valid_reg && (in_cmd_reg == CMD_SCAN) && load_ready;
    assign frame_load.frame = {mod2_byte, sel_byte, mod1_byte, sel_byte};

endmodule

>>> src/cdms_serializer.sv
// ----------------------------------------------------------------------------
// cdms_serializer: 32-bit frame shift register
// Presents the frame MSB first, one bit per output transaction, and marks
// the last bit as the latch point.
// ----------------------------------------------------------------------------
module cdms_serializer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdms_pkg::frame_load_t frame_load,
    output logic                  load_ready,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,
    output logic                  m_axis_tlast
);
    import cdms_pkg::*;

    logic [FRAME_W-1:0]   shift_reg;
    logic [FRAME_W-1:0]   shift_next;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [BIT_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 last_bit;
    logic                 take;

    assign last_bit   = (cnt_reg == BIT_CNT_W'(FRAME_W - 1));
    assign take       = busy_reg && m_axis_tready;
    assign load_ready = !busy_reg || (m_axis_tready && last_bit);

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (frame_load.load)
        begin
            shift_next = frame_load.frame;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (take)
        begin
            // Advance to the next bit, or go idle after the latch bit
            shift_next = {shift_reg[FRAME_W-2:0], 1'b0};
            cnt_next   = cnt_reg + BIT_CNT_W'(1);
            busy_next  = !last_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {7'b0, shift_reg[FRAME_W-1]};
    assign m_axis_tlast  = busy_reg && last_bit;

endmodule
